// File: rtl/life_cellular_automaton_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Life step unit assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LCAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LCAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lcas_pkg.sv
// ----------------------------------------------------------------------------
// Life step unit package
// Types, constants and helpers shared by the life step unit modules.
// ----------------------------------------------------------------------------
package lcas_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int DIM_W  = 9;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = 8;

    localparam logic [DIM_W-1:0] MIN_DIM        = DIM_W'(3);
    localparam logic [DIM_W-1:0] RST_WIDTH      = DIM_W'(240);
    localparam logic [DIM_W-1:0] RST_HEIGHT     = DIM_W'(160);
    localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic             next_alive;
        logic             born;
        logic             died;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
        logic             frame_last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    typedef struct packed {
        logic                  not_empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v < MIN_DIM) begin
            res = MIN_DIM;
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [1:0] count3(input logic [2:0] col);
        return {1'b0, col[0]} + {1'b0, col[1]} + {1'b0, col[2]};
    endfunction

endpackage

// File: rtl/lcas_cell_if.sv
// ----------------------------------------------------------------------------
// Cell input channel
// Valid/ready channel that carries one current-generation cell per request.
// ----------------------------------------------------------------------------
interface lcas_cell_if;
    logic valid;
    logic ready;
    logic cell_alive;

    modport source (output valid, output cell_alive, input ready);
    modport sink   (input valid, input cell_alive, output ready);
endinterface

// File: rtl/lcas_result_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries the next state of one interior cell.
// ----------------------------------------------------------------------------
interface lcas_result_if;
    logic       valid;
    logic       ready;
    logic       next_alive;
    logic       born;
    logic       died;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic       frame_last;

    modport source (output valid, output next_alive, output born, output died,
                    output cell_row, output cell_col, output frame_last, input ready);
    modport sink   (input valid, input next_alive, input born, input died,
                    input cell_row, input cell_col, input frame_last, output ready);
endinterface

// File: rtl/lcas_front.sv
// ----------------------------------------------------------------------------
// Life step front end
// Accepts cells, tracks the raster position, masks the border, keeps the line
// store of the two rows above and the 3x3 window, and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_step_unit_macros.svh"

module lcas_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lcas_cell_if.sink                            i_cell,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [lcas_pkg::DIM_W-1:0]           i_cfg_data,
    input  lcas_pkg::t_fifo_stat                 i_fifo_stat,
    output lcas_pkg::t_push                      o_push
);

    logic [lcas_pkg::DIM_W-1:0] r_width,  n_width;
    logic [lcas_pkg::DIM_W-1:0] r_height, n_height;
    logic [lcas_pkg::ROW_W-1:0] r_row,    n_row;
    logic [lcas_pkg::COL_W-1:0] r_col,    n_col;
    logic                       r_s1_valid, n_s1_valid;

    // Stage 1 payload
    logic                       r_s1_cell;
    logic                       r_s1_emit;
    logic                       r_s1_last;
    logic [lcas_pkg::ROW_W-1:0] r_s1_row;
    logic [lcas_pkg::COL_W-1:0] r_s1_col;
    logic [1:0]                 r_rd_data;   // {row above, row two above}
    logic [5:0]                 r_win;       // {center column, left column}

    logic [1:0] r_line_mem [lcas_pkg::MAX_WIDTH];

    logic                       w_accept;
    logic [lcas_pkg::DIM_W-1:0] w_row_inc;
    logic [lcas_pkg::DIM_W-1:0] w_col_inc;
    logic                       w_border;
    logic                       w_col_wrap;
    logic                       w_row_wrap;
    logic [lcas_pkg::FIFO_CNT_W:0] w_inflight;

    logic [2:0] w_cur;
    logic [2:0] w_left;
    logic [2:0] w_center;
    logic       w_alive;
    logic [3:0] w_nbr;
    logic       w_next;

    // Leave room in the queue for the item in stage 1 and the new one.
    assign w_inflight = {1'b0, i_fifo_stat.count} + {{lcas_pkg::FIFO_CNT_W{1'b0}}, r_s1_valid};
    assign i_cell.ready = w_inflight < (lcas_pkg::FIFO_CNT_W+1)'(lcas_pkg::FIFO_DEPTH);
    assign w_accept = i_cell.valid & i_cell.ready;

    assign w_row_inc  = {{(lcas_pkg::DIM_W-lcas_pkg::ROW_W){1'b0}}, r_row} + lcas_pkg::DIM_W'(1);
    assign w_col_inc  = {{(lcas_pkg::DIM_W-lcas_pkg::COL_W){1'b0}}, r_col} + lcas_pkg::DIM_W'(1);
    assign w_col_wrap = w_col_inc >= r_width;
    assign w_row_wrap = w_row_inc >= r_height;
    assign w_border   = (r_row == '0) || w_row_wrap || (r_col == '0) || w_col_wrap;

    always_comb begin
        n_width    = r_width;
        n_height   = r_height;
        n_row      = r_row;
        n_col      = r_col;
        n_s1_valid = w_accept;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcas_pkg::CFG_FRAME_WIDTH: begin
                    n_width = lcas_pkg::clamp_dim(i_cfg_data, lcas_pkg::MAX_WIDTH_DIM);
                end
                lcas_pkg::CFG_FRAME_HEIGHT: begin
                    n_height = lcas_pkg::clamp_dim(i_cfg_data, lcas_pkg::MAX_HEIGHT_DIM);
                end
                default: begin
                end
            endcase
            // restart the frame
            n_row = '0;
            n_col = '0;
        end else if (w_accept) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : w_row_inc[lcas_pkg::ROW_W-1:0];
            end else begin
                n_col = w_col_inc[lcas_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= lcas_pkg::RST_WIDTH;
            r_height   <= lcas_pkg::RST_HEIGHT;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_row      <= n_row;
            r_col      <= n_col;
            r_s1_valid <= n_s1_valid;
            if (r_s1_valid) begin
                r_win <= {w_cur, w_center};
            end
        end
    end

    // Line store: read at the accepted column, written back in the cycle after.
    // Consecutive cells sit in different columns, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_line_mem[r_col];
            r_s1_cell <= i_cell.cell_alive & ~w_border;
            r_s1_emit <= (r_row >= lcas_pkg::ROW_W'(2)) && (r_col >= lcas_pkg::COL_W'(2));
            r_s1_last <= (w_row_inc == r_height) && (w_col_inc == r_width);
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= {r_s1_cell, r_rd_data[1]};
        end
    end

    // column bits: 0 top, 1 middle, 2 bottom
    assign w_cur    = {r_s1_cell, r_rd_data[1], r_rd_data[0]};
    assign w_left   = r_win[2:0];
    assign w_center = r_win[5:3];
    assign w_alive  = w_center[1];
    assign w_nbr    = {2'b00, lcas_pkg::count3(w_left)} + {2'b00, lcas_pkg::count3(w_cur)}
                    + {3'b000, w_center[0]} + {3'b000, w_center[2]};
    assign w_next   = (w_nbr == 4'd3) || (w_alive && (w_nbr == 4'd2));

    always_comb begin
        o_push.valid           = r_s1_valid & r_s1_emit;
        o_push.data.next_alive = w_next;
        o_push.data.born       = ~w_alive & (w_nbr == 4'd3);
        o_push.data.died       = w_alive & ~w_next;
        o_push.data.cell_row   = lcas_pkg::POS_W'(r_s1_row - lcas_pkg::ROW_W'(1));
        o_push.data.cell_col   = lcas_pkg::POS_W'(r_s1_col - lcas_pkg::COL_W'(1));
        o_push.data.frame_last = r_s1_last;
    end

    `LCAS_ASSERT_NXT(a_accept_fills_s1, i_clk, i_rst_n, w_accept, r_s1_valid, "accepted cell did not reach stage 1")
    `LCAS_ASSERT_IMP(a_push_interior, i_clk, i_rst_n, o_push.valid, (o_push.data.cell_row != '0) && (o_push.data.cell_col != '0), "result pushed for a border cell")
    `LCAS_ASSERT_IMP(a_col_in_frame, i_clk, i_rst_n, w_accept, w_col_inc <= r_width, "column counter outside the frame")

endmodule

// File: rtl/lcas_fifo.sv
// ----------------------------------------------------------------------------
// Life step result queue
// Short queue between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_step_unit_macros.svh"

module lcas_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcas_pkg::t_push       i_push,
    input  logic                  i_pop,
    output lcas_pkg::t_result     o_head,
    output lcas_pkg::t_fifo_stat  o_stat
);

    lcas_pkg::t_result r_mem [lcas_pkg::FIFO_DEPTH];

    logic [lcas_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [lcas_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [lcas_pkg::FIFO_CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = r_wr_ptr + lcas_pkg::FIFO_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + lcas_pkg::FIFO_PTR_W'(1);
        end
        unique case ({i_push.valid, i_pop})
            2'b10:   n_count = r_count + lcas_pkg::FIFO_CNT_W'(1);
            2'b01:   n_count = r_count - lcas_pkg::FIFO_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.count     = r_count;
    assign o_stat.not_empty = r_count != '0;

    `LCAS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_count == lcas_pkg::FIFO_CNT_W'(lcas_pkg::FIFO_DEPTH), !i_push.valid, "push into a full queue")
    `LCAS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty queue")
    `LCAS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= lcas_pkg::FIFO_CNT_W'(lcas_pkg::FIFO_DEPTH), "queue count out of range")

endmodule

// File: rtl/lcas_back.sv
// ----------------------------------------------------------------------------
// Life step output stage
// Drains the result queue into the output register.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_step_unit_macros.svh"

module lcas_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcas_pkg::t_result     i_head,
    input  lcas_pkg::t_fifo_stat  i_stat,
    output logic                  o_pop,
    lcas_result_if.source         o_result
);

    logic              r_valid, n_valid;
    lcas_pkg::t_result r_data;

    // advance when the register is empty or being taken this cycle
    assign o_pop = i_stat.not_empty & (~r_valid | o_result.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.next_alive = r_data.next_alive;
    assign o_result.born       = r_data.born;
    assign o_result.died       = r_data.died;
    assign o_result.cell_row   = r_data.cell_row;
    assign o_result.cell_col   = r_data.cell_col;
    assign o_result.frame_last = r_data.frame_last;

    `LCAS_ASSERT_NXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid, "popped result not presented")
    `LCAS_ASSERT_NXT(a_idle_stays_empty, i_clk, i_rst_n, !r_valid && !i_stat.not_empty, !r_valid, "result appeared from an empty queue")
    `LCAS_ASSERT_IMP(a_born_died_excl, i_clk, i_rst_n, r_valid, !(r_data.born && r_data.died), "cell both born and died")

endmodule

// File: rtl/life_cellular_automaton_step_unit.sv
// ----------------------------------------------------------------------------
// Life cellular automaton step unit
// One generation of the B3/S23 rule over a raster stream of cells.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one per clock while the queue has room, and
// the block reports each interior cell's next state once the cell one row
// below and one column to the right has arrived. A result passes from the
// stage 1 register through the queue into the output register. The rate
// of one cell a clock is set by the line store, which is read once and
// written once per cell. A short queue decouples the rule pipeline from the
// output, so input keeps flowing while a result waits to be taken. The line
// store has no clear: the first two rows after reset fill it before anything
// is read that reaches a result. Writing either frame register restarts the
// frame at row zero, column zero; write them only while the block is idle.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lcas_cell_if.sink                   i_cell,
    lcas_result_if.source               o_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [lcas_pkg::DIM_W-1:0]  i_cfg_data
);

    lcas_pkg::t_push      w_push;
    lcas_pkg::t_result    w_head;
    lcas_pkg::t_fifo_stat w_stat;
    logic                 w_pop;

    lcas_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (i_cell),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_stat (w_stat),
        .o_push      (w_push)
    );

    lcas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    lcas_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Life step unit testbench
// Streams raster frames of cells into the step unit and checks every interior
// result against a behavioral life predictor kept inside the bench. A short
// directed plan covers out-of-range dimensions, ignored border cells and
// frame restart. Random frames of many sizes follow, including the widest
// and the tallest frame; both channels idle at random but in the widest frame.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT  = 200000;
    localparam int SETTLE     = 8;
    localparam int IDLE_PCT   = 6;
    localparam int SHOW_LIMIT = 10;

    localparam lcas_pkg::t_result NONE = '0;
    localparam lcas_pkg::t_result LONE_DIES = '{next_alive: 1'b0, born: 1'b0, died: 1'b1,
                                      cell_row: 8'd1, cell_col: 8'd1, frame_last: 1'b1};
    localparam lcas_pkg::t_result STAYS_DEAD = '{next_alive: 1'b0, born: 1'b0, died: 1'b0,
                                       cell_row: 8'd1, cell_col: 8'd1, frame_last: 1'b1};

    typedef struct {
        bit                         wr;
        logic                       idx;
        logic [lcas_pkg::DIM_W-1:0] data;
        bit                         alive;
        bit                         known;
        lcas_pkg::t_result          want;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_index;
    logic [lcas_pkg::DIM_W-1:0] i_cfg_data;

    lcas_cell_if   cell_ch ();
    lcas_result_if res_ch ();

    // typed result riding along with the request in flight
    logic              note_on;
    lcas_pkg::t_result note_val;

    bit          calm;
    int unsigned cycles;
    int unsigned err_count;

    // predictor state
    bit          row_up1 [lcas_pkg::MAX_WIDTH];
    bit          row_up2 [lcas_pkg::MAX_WIDTH];
    logic [5:0]  win_cols;
    int unsigned at_row;
    int unsigned at_col;
    int unsigned frame_w;
    int unsigned frame_h;

    lcas_pkg::t_result next_gen_q [$];

    // frame A: lone live center among live border cells, which count as dead
    // partial frame, then a restart on a height write
    // frame B: dead center inside a live border
    t_plan_row plan [25] = '{
        '{1'b1, lcas_pkg::CFG_FRAME_WIDTH,  9'd0, 1'b0, 1'b0, NONE},
        '{1'b1, lcas_pkg::CFG_FRAME_HEIGHT, 9'd2, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b1, LONE_DIES},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b1, lcas_pkg::CFG_FRAME_HEIGHT, 9'd1, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 9'd0, 1'b1, 1'b1, STAYS_DEAD}
    };

    life_cellular_automaton_step_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (cell_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned fit_dim(input logic [lcas_pkg::DIM_W-1:0] v,
                                            input int unsigned top);
        if (v < 3) return 3;
        if (v > top) return top;
        return v;
    endfunction

    // One raster step of the life rule; returns 1 when an interior cell is reported.
    function automatic bit next_generation_cell(input bit alive_in,
                                                output lcas_pkg::t_result res);
        bit          cell_now;
        bit          up1;
        bit          up2;
        bit          was_alive;
        bit          made;
        logic [2:0]  cur_col;
        logic [2:0]  left_col;
        logic [2:0]  mid_col;
        int unsigned n;
        cell_now = alive_in;
        if (at_row == 0 || at_row + 1 >= frame_h || at_col == 0 || at_col + 1 >= frame_w) begin
            cell_now = 1'b0;
        end
        up2 = row_up2[at_col];
        up1 = row_up1[at_col];
        row_up2[at_col] = up1;
        row_up1[at_col] = cell_now;
        cur_col  = {cell_now, up1, up2};
        left_col = win_cols[2:0];
        mid_col  = win_cols[5:3];
        res  = '0;
        made = 1'b0;
        if (at_row >= 2 && at_col >= 2) begin
            was_alive = mid_col[1];
            n = $countones(left_col) + $countones(cur_col) + $countones(mid_col) - was_alive;
            res.next_alive = (n == 3) || (was_alive && n == 2);
            res.born       = !was_alive && n == 3;
            res.died       = was_alive && !res.next_alive;
            res.cell_row   = 8'(at_row - 1);
            res.cell_col   = 8'(at_col - 1);
            res.frame_last = (at_row + 1 == frame_h) && (at_col + 1 == frame_w);
            made = 1'b1;
        end
        win_cols = {cur_col, mid_col};
        at_col++;
        if (at_col >= frame_w) begin
            at_col = 0;
            at_row++;
            if (at_row >= frame_h) at_row = 0;
        end
        return made;
    endfunction

    task automatic report(input string what, input lcas_pkg::t_result want,
                          input lcas_pkg::t_result got);
        err_count++;
        if (err_count <= SHOW_LIMIT) begin
            $display("%s at cycle %0d: expected next=%0b born=%0b died=%0b row=%0d col=%0d last=%0b",
                     what, cycles,
                     want.next_alive, want.born, want.died, want.cell_row, want.cell_col,
                     want.frame_last);
            $display("    got next=%0b born=%0b died=%0b row=%0d col=%0d last=%0b",
                     got.next_alive, got.born, got.died, got.cell_row, got.cell_col,
                     got.frame_last);
        end
    endtask

    always @(posedge i_clk) begin : watch
        lcas_pkg::t_result calc;
        lcas_pkg::t_result got;
        lcas_pkg::t_result want;
        bit                made;
        bit                bad;
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == lcas_pkg::CFG_FRAME_WIDTH) begin
                    frame_w = fit_dim(i_cfg_data, lcas_pkg::MAX_WIDTH);
                end else begin
                    frame_h = fit_dim(i_cfg_data, lcas_pkg::MAX_HEIGHT);
                end
                at_row = 0;
                at_col = 0;
            end
            if (cell_ch.valid && cell_ch.ready) begin
                made = next_generation_cell(cell_ch.cell_alive, calc);
                if (note_on) begin
                    next_gen_q.push_back(note_val);
                end else if (made) begin
                    next_gen_q.push_back(calc);
                end
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{next_alive: res_ch.next_alive, born: res_ch.born, died: res_ch.died,
                        cell_row: res_ch.cell_row, cell_col: res_ch.cell_col,
                        frame_last: res_ch.frame_last};
                if (next_gen_q.size() == 0) begin
                    report("unexpected result", NONE, got);
                end else begin
                    want = next_gen_q.pop_front();
                    bad = (got.next_alive !== want.next_alive) || (got.born !== want.born) ||
                          (got.died !== want.died) || (got.cell_row !== want.cell_row) ||
                          (got.cell_col !== want.cell_col) ||
                          (got.frame_last !== want.frame_last);
                    if (bad) report("result mismatch", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_cell(input bit alive, input bit known, input lcas_pkg::t_result want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cell_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_alive <= alive;
        note_on            <= known;
        note_val           <= want;
        do @(posedge i_clk); while (!cell_ch.ready);
    endtask

    // hold the sender until every pending result is out, then let the pipe empty
    task automatic drain(input int unsigned extra);
        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        note_on       <= 1'b0;
        while (next_gen_q.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [lcas_pkg::DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_cells(input int unsigned count, input int unsigned dens,
                             input int unsigned pause_at);
        for (int unsigned i = 0; i < count; i++) begin
            if (pause_at != 0 && i == pause_at) drain(0);
            send_cell($urandom_range(99) < dens, 1'b0, NONE);
        end
    endtask

    function automatic logic [lcas_pkg::DIM_W-1:0] pick_dim(input int unsigned top);
        if ($urandom_range(7) == 0) return lcas_pkg::DIM_W'($urandom_range(2));
        return lcas_pkg::DIM_W'($urandom_range(3, top));
    endfunction

    initial begin
        int unsigned sent;
        int unsigned count;
        int unsigned area;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = lcas_pkg::CFG_FRAME_WIDTH;
        i_cfg_data         = '0;
        cell_ch.valid      = 1'b0;
        cell_ch.cell_alive = 1'b0;
        res_ch.ready       = 1'b0;
        note_on            = 1'b0;
        note_val           = NONE;
        calm               = 1'b0;
        cycles             = 0;
        err_count          = 0;
        win_cols           = '0;
        at_row             = 0;
        at_col             = 0;
        frame_w            = lcas_pkg::RST_WIDTH;
        frame_h            = lcas_pkg::RST_HEIGHT;
        sent               = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].wr) begin
                drain(SETTLE);
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_cell(plan[k].alive, plan[k].known, plan[k].want);
            end
        end

        // small random frames, some cut short by the next register write
        while (sent < 60) begin
            drain(SETTLE);
            case ($urandom_range(2))
                0: write_reg(lcas_pkg::CFG_FRAME_WIDTH, pick_dim(12));
                1: write_reg(lcas_pkg::CFG_FRAME_HEIGHT, pick_dim(8));
                default: begin
                    write_reg(lcas_pkg::CFG_FRAME_WIDTH, pick_dim(12));
                    write_reg(lcas_pkg::CFG_FRAME_HEIGHT, pick_dim(8));
                end
            endcase
            area  = frame_w * frame_h;
            count = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
            run_cells(count, $urandom_range(10, 70),
                      ($urandom_range(2) == 0) ? $urandom_range(1, count - 1) : 0);
            sent += count;
        end

        // widest frame, with no idling on either side
        drain(SETTLE);
        write_reg(lcas_pkg::CFG_FRAME_WIDTH, 9'h1FF);
        write_reg(lcas_pkg::CFG_FRAME_HEIGHT, 9'd3);
        calm = 1'b1;
        run_cells(lcas_pkg::MAX_WIDTH * 3, 45, 0);
        drain(SETTLE);
        calm = 1'b0;

        // tallest frame
        write_reg(lcas_pkg::CFG_FRAME_WIDTH, 9'd3);
        write_reg(lcas_pkg::CFG_FRAME_HEIGHT, 9'h100);
        run_cells(lcas_pkg::MAX_HEIGHT * 3, 50, 0);

        drain(0);
        repeat (12) @(posedge i_clk);
        err_count += next_gen_q.size();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
